### hdl/mlpq_pkg.sv
package mlpq_pkg;

   // operation codes on req_func
   typedef enum logic [1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_PEEK   = 2'd1,
      FUNC_GET    = 2'd2
   } func_type;

   // result codes on rsp_status
   typedef enum logic [2:0] {
      ST_INSERTED = 3'd0,
      ST_BADLEVEL = 3'd1,
      ST_FULL     = 3'd2,
      ST_EMPTY    = 3'd3,
      ST_ENTRY    = 3'd4
   } status_type;

   localparam int          VALUE_W       = 32;
   localparam int          ITEM_LEVEL_W  = 8;
   localparam int          OUT_LEVEL_W   = 4;
   localparam int          LIMIT_W       = 5;
   localparam logic [4:0]  LIMIT_RESET   = 5'd16;

   // command broadcast to every cell of the chain
   typedef struct packed {
      logic ins;   // insert the new word in level order
      logic rem;   // drop the head, everything moves one cell forward
   } cell_ctl_type;

endpackage

### hdl/mlpq_cell.sv
module mlpq_cell #(
   parameter int LW = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mlpq_pkg::cell_ctl_type ctl,
   input  logic [LW-1:0]         new_level,
   input  logic signed [31:0]    new_value,
   // neighbour towards the head
   input  logic                  prev_valid,
   input  logic [LW-1:0]         prev_level,
   input  logic signed [31:0]    prev_value,
   input  logic                  prev_keep,
   // neighbour towards the tail
   input  logic                  next_valid,
   input  logic [LW-1:0]         next_level,
   input  logic signed [31:0]    next_value,
   // own contents
   output logic                  valid,
   output logic [LW-1:0]         level,
   output logic signed [31:0]    value,
   output logic                  keep
);
   import mlpq_pkg::*;

   logic                valid_ff, valid_in;
   logic [LW-1:0]       level_ff, level_in;
   logic signed [31:0]  value_ff, value_in;

   // an entry stays put when it is at or ahead of the new word's level
   assign keep = valid_ff && (level_ff <= new_level);

   // next contents: hold, take the new word, or take a neighbour's word
   always_comb begin
      valid_in = valid_ff;
      level_in = level_ff;
      value_in = value_ff;
      if (ctl.rem) begin
         valid_in = next_valid;
         level_in = next_level;
         value_in = next_value;
      end else if (ctl.ins && !keep) begin
         if (prev_keep) begin
            valid_in = 1'b1;
            level_in = new_level;
            value_in = new_value;
         end else begin
            valid_in = prev_valid;
            level_in = prev_level;
            value_in = prev_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff <= level_in;
      value_ff <= value_in;
   end

   assign valid = valid_ff;
   assign level = level_ff;
   assign value = value_ff;

endmodule

### hdl/multilevel_priority_fifo_queue.sv
// channel   ports                                   handshake
// request   req_func, req_item_value, req_item_level  start high while busy low
// response  rsp_status, rsp_out_value, rsp_out_level  rsp_strobe, one cycle
// config    csr_wr_data                              csr_wr_en
//
// every operation first registers the word, then has an execute cycle in which
// the whole cell chain shifts or holds and the result register loads.
// the result shows on the cycle after that; busy is high for one cycle.
// reset empties the chain at once (valid bits only) and sets the level limit
// to sixteen. the receiver cannot stall the response.
module multilevel_priority_fifo_queue #(
   parameter int MAX_LEVELS = 16,
   parameter int CAPACITY   = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_func,
   input  logic signed [31:0] req_item_value,
   input  logic [7:0]         req_item_level,
   output logic               rsp_strobe,
   output logic [2:0]         rsp_status,
   output logic signed [31:0] rsp_out_value,
   output logic [3:0]         rsp_out_level,
   input  logic               csr_wr_en,
   input  logic [4:0]         csr_wr_data
);
   import mlpq_pkg::*;

   localparam int LW = (MAX_LEVELS > 2) ? $clog2(MAX_LEVELS) : 1;
   localparam int XW = (LW > OUT_LEVEL_W) ? LW : OUT_LEVEL_W;

   logic [LIMIT_W-1:0]       limit_ff;
   logic                     pending_ff;
   logic [1:0]               func_ff;
   logic signed [31:0]       value_ff;
   logic [ITEM_LEVEL_W-1:0]  level_ff;

   logic                     strobe_ff;
   logic [2:0]               status_ff, status_in;
   logic signed [31:0]       oval_ff, oval_in;
   logic [3:0]               olvl_ff, olvl_in;

   cell_ctl_type             ctl;
   logic [ITEM_LEVEL_W-1:0]  limit_eff;
   logic                     bad_level, full, head_valid;
   logic [XW-1:0]            head_level_x;
   func_type                 func_e;

   logic                     valid_w [CAPACITY];
   logic [LW-1:0]            level_w [CAPACITY];
   logic signed [31:0]       value_w [CAPACITY];
   logic                     keep_w  [CAPACITY];
   logic [CAPACITY-1:0]      valid_vec;

   // level limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
      end else begin
         pending_ff <= start && !pending_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !pending_ff) begin
         func_ff  <= req_func;
         value_ff <= req_item_value;
         level_ff <= req_item_level;
      end
   end

   assign busy = pending_ff;

   // level limit check and checks on the head and tail cells
   assign limit_eff    = (ITEM_LEVEL_W'(limit_ff) > ITEM_LEVEL_W'(MAX_LEVELS)) ?
                         ITEM_LEVEL_W'(MAX_LEVELS) : ITEM_LEVEL_W'(limit_ff);
   assign bad_level    = level_ff >= limit_eff;
   assign full         = valid_w[CAPACITY-1];
   assign head_valid   = valid_w[0];
   assign head_level_x = XW'(level_w[0]);
   assign func_e       = func_type'(func_ff);

   // operation decode and result
   always_comb begin
      ctl       = '0;
      status_in = ST_EMPTY;
      oval_in   = '0;
      olvl_in   = '0;
      case (func_e)
         FUNC_INSERT: begin
            if (bad_level) begin
               status_in = ST_BADLEVEL;
            end else if (full) begin
               status_in = ST_FULL;
            end else begin
               status_in = ST_INSERTED;
               ctl.ins   = pending_ff;
            end
         end
         FUNC_PEEK, FUNC_GET: begin
            if (head_valid) begin
               status_in = ST_ENTRY;
               oval_in   = value_w[0];
               olvl_in   = head_level_x[OUT_LEVEL_W-1:0];
               ctl.rem   = pending_ff && (func_e == FUNC_GET);
            end
         end
         default: begin
            status_in = ST_EMPTY;
         end
      endcase
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= pending_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pending_ff) begin
         status_ff <= status_in;
         oval_ff   <= oval_in;
         olvl_ff   <= olvl_in;
      end
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_status    = status_ff;
   assign rsp_out_value = oval_ff;
   assign rsp_out_level = olvl_ff;

   // chain of cells kept in level order, oldest first within a level
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic               p_valid, p_keep, n_valid;
      logic [LW-1:0]      p_level, n_level;
      logic signed [31:0] p_value, n_value;

      if (i == 0) begin : g_head
         assign p_valid = 1'b0;
         assign p_level = '0;
         assign p_value = '0;
         assign p_keep  = 1'b1;
      end else begin : g_body
         assign p_valid = valid_w[i-1];
         assign p_level = level_w[i-1];
         assign p_value = value_w[i-1];
         assign p_keep  = keep_w[i-1];
      end

      if (i == CAPACITY-1) begin : g_tail
         assign n_valid = 1'b0;
         assign n_level = '0;
         assign n_value = '0;
      end else begin : g_link
         assign n_valid = valid_w[i+1];
         assign n_level = level_w[i+1];
         assign n_value = value_w[i+1];
      end

      mlpq_cell #(
         .LW (LW)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .new_level  (level_ff[LW-1:0]),
         .new_value  (value_ff),
         .prev_valid (p_valid),
         .prev_level (p_level),
         .prev_value (p_value),
         .prev_keep  (p_keep),
         .next_valid (n_valid),
         .next_level (n_level),
         .next_value (n_value),
         .valid      (valid_w[i]),
         .level      (level_w[i]),
         .value      (value_w[i]),
         .keep       (keep_w[i])
      );

      assign valid_vec[i] = valid_w[i];
   end

`ifndef SYNTHESIS
   // an execute cycle is never followed by another and is always answered
   a_one_exec: assert property (@(posedge clock) disable iff (reset)
      pending_ff |=> (!pending_ff && rsp_strobe))
      else $error("execute cycle not followed by a response");

   // occupied cells always form an unbroken run from the head
   a_packed: assert property (@(posedge clock) disable iff (reset)
      ((valid_vec & (valid_vec + 1'b1)) == '0))
      else $error("gap in the cell chain");

   // a successful insert grows the chain by one cell
   a_ins_grow: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == ST_INSERTED)) |->
      ($countones(valid_vec) == $past($countones(valid_vec)) + 1))
      else $error("insert did not add one entry");

   // rejected or empty results leave the chain untouched
   a_no_change: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == ST_BADLEVEL || rsp_status == ST_FULL ||
                      rsp_status == ST_EMPTY)) |->
      (valid_vec == $past(valid_vec)))
      else $error("chain changed on a refused operation");

   // a full report only when the last cell was occupied
   a_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == ST_FULL)) |-> $past(full))
      else $error("full reported with free cells");
`endif

endmodule
